// ----- design/pvd_pkg.sv -----
// shared types and constants for the pcm volume to dac8 upsampler
package pvd_pkg;

    localparam int MAX_REPEAT = 64;
    localparam int CNT_W      = $clog2(MAX_REPEAT + 1);
    localparam int CFG_W      = 7;
    localparam int QDEPTH     = 4;

    localparam logic [6:0] VOL_FULL     = 7'd100;
    localparam logic [6:0] RESET_VOLUME = 7'd20;
    localparam logic [6:0] RESET_REPEAT = 7'd1;

    // x = mag * vol + 50 stays below 2^22, so (x * RECIP) >> RECIP_SH is exact floor(x / 100)
    localparam int          RECIP_SH = 29;
    localparam logic [22:0] RECIP    = 23'd5368710;
    localparam logic [21:0] HALF_DIV = 22'd50;

    localparam logic [1:0] CFG_MODE   = 2'd0;
    localparam logic [1:0] CFG_VOLUME = 2'd1;
    localparam logic [1:0] CFG_REPEAT = 2'd2;

    typedef struct packed {
        logic       sixteen_bit_mode;
        logic [6:0] volume_percent;
        logic [6:0] repeat_factor;
    } t_cfg;

    typedef struct packed {
        logic [7:0]       code;
        logic [CNT_W-1:0] count;
    } t_run;

endpackage

// ----- design/pvd_front.sv -----
// front end: accepts sample words, scales them and builds dac code runs
module pvd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  pvd_pkg::t_cfg i_cfg,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [15:0]   i_word,
    output logic          o_run_valid,
    input  logic          i_run_ready,
    output pvd_pkg::t_run o_run
);

    logic                      en;
    logic                      neg_in;
    logic [15:0]               mag_in;
    logic [6:0]                vol_in;
    logic [pvd_pkg::CNT_W-1:0] cnt_in;
    logic [44:0]               prod;
    logic [16:0]               sv;

    logic                      r_a_v, r_b_v, r_c_v;
    logic                      r_a_neg, r_b_neg, r_c_neg;
    logic                      r_a_mode, r_b_mode, r_c_mode;
    logic [pvd_pkg::CNT_W-1:0] r_a_cnt, r_b_cnt, r_c_cnt;
    logic [15:0]               r_a_mag;
    logic [6:0]                r_a_vol;
    logic [21:0]               r_b_x;
    logic [15:0]               r_c_q;

    // whole pipe advances unless the last stage is blocked
    assign en      = !r_c_v || i_run_ready;
    assign o_ready = en;

    always_comb begin
        if (i_cfg.sixteen_bit_mode) begin
            neg_in = i_word[15];
            mag_in = i_word[15] ? (~i_word + 16'd1) : i_word;
        end else begin
            neg_in = !i_word[7];
            mag_in = i_word[7] ? {8'd0, i_word[7:0] - 8'd128}
                               : {8'd0, 8'd128 - i_word[7:0]};
        end
        // full volume divides mag * 100 by 100, which leaves it unchanged
        vol_in = (i_cfg.volume_percent >= pvd_pkg::VOL_FULL) ? pvd_pkg::VOL_FULL
                                                             : i_cfg.volume_percent;
        if (i_cfg.repeat_factor == 7'd0) begin
            cnt_in = pvd_pkg::CNT_W'(1);
        end else if (i_cfg.repeat_factor > 7'(pvd_pkg::MAX_REPEAT)) begin
            cnt_in = pvd_pkg::CNT_W'(pvd_pkg::MAX_REPEAT);
        end else begin
            cnt_in = pvd_pkg::CNT_W'(i_cfg.repeat_factor);
        end
    end

    assign prod = {23'd0, r_b_x} * {22'd0, pvd_pkg::RECIP};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
        end else if (en) begin
            r_a_v <= i_valid;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_neg  <= neg_in;
            r_a_mode <= i_cfg.sixteen_bit_mode;
            r_a_cnt  <= cnt_in;
            r_a_mag  <= mag_in;
            r_a_vol  <= vol_in;

            r_b_neg  <= r_a_neg;
            r_b_mode <= r_a_mode;
            r_b_cnt  <= r_a_cnt;
            r_b_x    <= ({6'd0, r_a_mag} * {15'd0, r_a_vol}) + pvd_pkg::HALF_DIV;

            r_c_neg  <= r_b_neg;
            r_c_mode <= r_b_mode;
            r_c_cnt  <= r_b_cnt;
            r_c_q    <= prod[pvd_pkg::RECIP_SH +: 16];
        end
    end

    // 16-bit mode takes bits 15:8, 8-bit mode bits 7:0; adding 128 flips the top bit
    assign sv          = r_c_neg ? (17'd0 - {1'b0, r_c_q}) : {1'b0, r_c_q};
    assign o_run_valid = r_c_v;
    assign o_run.code  = r_c_mode ? (sv[15:8] ^ 8'h80) : (sv[7:0] ^ 8'h80);
    assign o_run.count = r_c_cnt;

endmodule

// ----- design/pvd_queue.sv -----
// small fifo of pending runs between front and back
module pvd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    input  pvd_pkg::t_run i_run,
    output logic          o_pop_valid,
    input  logic          i_pop_ready,
    output pvd_pkg::t_run o_run
);

    localparam int PTR_W = $clog2(pvd_pkg::QDEPTH);
    localparam int CNT_W = $clog2(pvd_pkg::QDEPTH + 1);

    pvd_pkg::t_run      r_mem [pvd_pkg::QDEPTH];
    logic [PTR_W-1:0]   r_wr;
    logic [PTR_W-1:0]   r_rd;
    logic [CNT_W-1:0]   r_fill;
    logic               push;
    logic               pop;

    assign o_push_ready = r_fill != CNT_W'(pvd_pkg::QDEPTH);
    assign o_pop_valid  = r_fill != CNT_W'(0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_run        = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PTR_W'(pvd_pkg::QDEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (pop) begin
                r_rd <= (r_rd == PTR_W'(pvd_pkg::QDEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (push && !pop) begin
                r_fill <= r_fill + CNT_W'(1);
            end else if (pop && !push) begin
                r_fill <= r_fill - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_run;
        end
    end

endmodule

// ----- design/pvd_back.sv -----
// back end: plays each run out as repeated dac words from an output register
module pvd_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_run_valid,
    output logic          o_run_ready,
    input  pvd_pkg::t_run i_run,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [7:0]    o_dac_code,
    output logic          o_last_of_run
);

    logic                      r_valid;
    logic [7:0]                r_code;
    logic [pvd_pkg::CNT_W-1:0] r_cnt;
    logic                      last;
    logic                      fire;
    logic                      take;

    assign last        = r_cnt == pvd_pkg::CNT_W'(1);
    assign fire        = r_valid && i_ready;
    // next run loads straight behind the last copy of the current one
    assign o_run_ready = !r_valid || (i_ready && last);
    assign take        = i_run_valid && o_run_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cnt   <= '0;
        end else if (take) begin
            r_valid <= 1'b1;
            r_cnt   <= i_run.count;
        end else if (fire) begin
            if (last) begin
                r_valid <= 1'b0;
            end else begin
                r_cnt <= r_cnt - pvd_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_code <= i_run.code;
        end
    end

    assign o_valid       = r_valid;
    assign o_dac_code    = r_code;
    assign o_last_of_run = r_valid && last;

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_cnt != '0) && (r_cnt <= pvd_pkg::CNT_W'(pvd_pkg::MAX_REPEAT)))
        else $error("run count out of range while a word is shown");

    a_run_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && !last) |=> r_valid && (r_code == $past(r_code))
                            && (r_cnt == $past(r_cnt) - pvd_pkg::CNT_W'(1)))
        else $error("run did not continue with the same code");

    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && last && !i_run_valid) |=> !r_valid)
        else $error("output still valid after the last copy with no run queued");
`endif

endmodule

// ----- design/pcm_volume_to_dac8_upsampler.sv -----
// top level: config registers, front end, run queue and playback back end
//
//  channel   direction  handshake                        payload
//  sample    in         i_sample_valid / o_sample_ready  i_sample_word
//  dac       out        o_dac_valid / i_dac_ready        o_dac_code, o_last_of_run
//  config    in         i_cfg_we (no wait)               i_cfg_addr, i_cfg_wdata
//
//  each sample gives repeat_factor (clamped to 1..64) words, one per cycle at most,
//  all of them shown from the output register
//  the front end is three stages (magnitude, scale, divide by 100 by reciprocal)
//  a four-word run queue lets the front keep accepting while the back plays out
//  synchronous active-low reset clears control state, config returns to 1 / 20 / 1
module pcm_volume_to_dac8_upsampler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_sample_valid,
    output logic        o_sample_ready,
    input  logic [15:0] i_sample_word,
    output logic        o_dac_valid,
    input  logic        i_dac_ready,
    output logic [7:0]  o_dac_code,
    output logic        o_last_of_run,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [pvd_pkg::CFG_W-1:0] i_cfg_wdata
);

    pvd_pkg::t_cfg r_cfg;
    pvd_pkg::t_run front_run;
    pvd_pkg::t_run back_run;
    logic          front_valid;
    logic          front_ready;
    logic          back_valid;
    logic          back_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sixteen_bit_mode <= 1'b1;
            r_cfg.volume_percent   <= pvd_pkg::RESET_VOLUME;
            r_cfg.repeat_factor    <= pvd_pkg::RESET_REPEAT;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                pvd_pkg::CFG_MODE:   r_cfg.sixteen_bit_mode <= i_cfg_wdata[0];
                pvd_pkg::CFG_VOLUME: r_cfg.volume_percent   <= i_cfg_wdata[6:0];
                pvd_pkg::CFG_REPEAT: r_cfg.repeat_factor    <= i_cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    pvd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (i_sample_valid),
        .o_ready     (o_sample_ready),
        .i_word      (i_sample_word),
        .o_run_valid (front_valid),
        .i_run_ready (front_ready),
        .o_run       (front_run)
    );

    pvd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_run        (front_run),
        .o_pop_valid  (back_valid),
        .i_pop_ready  (back_ready),
        .o_run        (back_run)
    );

    pvd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_run_valid   (back_valid),
        .o_run_ready   (back_ready),
        .i_run         (back_run),
        .o_valid       (o_dac_valid),
        .i_ready       (i_dac_ready),
        .o_dac_code    (o_dac_code),
        .o_last_of_run (o_last_of_run)
    );

endmodule
